### hw/rtl/ttps_pkg.sv
`timescale 1ns / 1ps

package ttps_pkg;

    // Table geometry and stored move width
    localparam int INDEX_BITS = 16;
    localparam int MOVE_BITS  = 16;
    localparam int TBL_DEPTH  = 1 << INDEX_BITS;

    // Fixed field widths
    localparam int KEY_W   = 64;
    localparam int DEPTH_W = 7;
    localparam int SCORE_W = 21;
    localparam int HMOVE_W = 16;
    localparam int EDEPTH_W = 8;

    // Stream payload sizes: fields packed from bit 0, padded to whole bytes
    localparam int IN_FIELDS_W  = KEY_W + DEPTH_W + 3 * SCORE_W + HMOVE_W;
    localparam int S_TDATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int IN_PAD_W     = S_TDATA_W - IN_FIELDS_W;
    localparam int OUT_FIELDS_W = 2 + 3 * SCORE_W + HMOVE_W + 1;
    localparam int M_TDATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = M_TDATA_W - OUT_FIELDS_W;

    localparam logic [HMOVE_W-1:0] NO_MOVE = '0;

    typedef enum logic [0:0] {
        OP_PROBE = 1'b0,
        OP_STORE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        BND_EXACT = 2'd0,
        BND_LOWER = 2'd1,
        BND_UPPER = 2'd2
    } bound_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RESOLVE
    } state_t;

    // Input request, first field in the lowest bits
    typedef struct packed {
        logic [IN_PAD_W-1:0]       pad;
        logic [HMOVE_W-1:0]        move_code;
        logic signed [SCORE_W-1:0] score;
        logic signed [SCORE_W-1:0] beta;
        logic signed [SCORE_W-1:0] alpha;
        logic [DEPTH_W-1:0]        depth;
        logic [KEY_W-1:0]          key;
    } in_t;

    // Result, first field in the lowest bits
    typedef struct packed {
        logic [OUT_PAD_W-1:0]      pad;
        logic                      written;
        logic [HMOVE_W-1:0]        hint_move;
        logic signed [SCORE_W-1:0] new_beta;
        logic signed [SCORE_W-1:0] new_alpha;
        logic signed [SCORE_W-1:0] cut_value;
        logic                      cut;
        logic                      hit;
    } out_t;

    // One table entry as kept in memory
    typedef struct packed {
        logic [KEY_W-1:0]           key;
        logic signed [SCORE_W-1:0]  value;
        logic signed [EDEPTH_W-1:0] depth;
        bound_t                     bound;
        logic [MOVE_BITS-1:0]       move;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Empty slot: zero key and value, depth minus one, exact bound, no move
    localparam entry_t EMPTY_ENTRY = '{
        key:   '0,
        value: '0,
        depth: '1,
        bound: BND_EXACT,
        move:  '0
    };

endpackage

### hw/rtl/transposition_table_probe_store.sv
// A request accepted on s_axis is registered while its slot is read from memory; the resolve
// step loads the result register once it is free. No new request is taken until the last resolves.
// A result waiting on m_axis does not block the next request; it only stalls the resolve step.
// Reset (rst_n, asynchronous, active low) clears control state and starts a clearing pass
// that writes an empty entry to each of the 2^INDEX_BITS (65536) slots; s_axis_tready
// stays low until the pass is done.
`timescale 1ns / 1ps

module transposition_table_probe_store (
    input  logic                           clk,
    input  logic                           rst_n,
    // s_axis_tdata, from bit 0: key[63:0], depth[6:0], alpha[20:0], beta[20:0],
    // score[20:0], move_code[15:0], zero pad
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [ttps_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // s_axis_tuser, from bit 0: operation (0 probe, 1 store)
    input  logic                           s_axis_tuser,
    // m_axis_tdata, from bit 0: hit, cut, cut_value[20:0], new_alpha[20:0],
    // new_beta[20:0], hint_move[15:0], written, zero pad
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [ttps_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    import ttps_pkg::*;

    // Control state
    state_t                state_reg, state_next;
    logic [INDEX_BITS-1:0] clr_cnt_reg, clr_cnt_next;
    logic                  out_valid_reg, out_valid_next;

    // Payload registers
    in_t  in_reg, in_next;
    op_t  op_reg, op_next;
    out_t out_data_reg, out_data_next;

    // Memory ports
    logic                  ram_we;
    logic [INDEX_BITS-1:0] ram_waddr;
    entry_t                ram_wentry;
    logic                  ram_re;
    logic [INDEX_BITS-1:0] ram_raddr;
    logic [ENTRY_W-1:0]    ram_rdata;
    entry_t                rd_entry;

    // Resolve datapath
    in_t                       s_req;
    logic                      accept;
    logic                      out_free;
    logic                      key_match;
    logic                      deep_enough;
    logic                      store_wins;
    logic                      cut;
    logic signed [SCORE_W-1:0] narrow_alpha;
    logic signed [SCORE_W-1:0] narrow_beta;
    bound_t                    store_bound;
    out_t                      result;

    assign s_req    = in_t'(s_axis_tdata);
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign rd_entry = entry_t'(ram_rdata);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Read the slot in the cycle the request is accepted; the word holds until the next read.
    assign ram_re    = accept;
    assign ram_raddr = s_req.key[INDEX_BITS-1:0];

    ttps_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TBL_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wentry),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Compare full key and depths against the stored entry.
    // Stored depth is signed so an empty slot (minus one) never reaches any asked depth.
    assign key_match   = (rd_entry.key == in_reg.key);
    assign deep_enough = ($signed(rd_entry.depth) >= $signed({1'b0, in_reg.depth}));
    assign store_wins  = !key_match
                         || ($signed({1'b0, in_reg.depth}) >= $signed(rd_entry.depth));

    // Probe: narrow the window by a bound entry, cut on exact or on a closed window
    always_comb
    begin
        narrow_alpha = in_reg.alpha;
        narrow_beta  = in_reg.beta;
        cut          = 1'b0;
        if (key_match && deep_enough)
        begin
            case (rd_entry.bound)
                BND_EXACT:
                begin
                    cut = 1'b1;
                end
                BND_LOWER:
                begin
                    if ($signed(rd_entry.value) > in_reg.alpha)
                    begin
                        narrow_alpha = rd_entry.value;
                    end
                end
                BND_UPPER:
                begin
                    if ($signed(rd_entry.value) < in_reg.beta)
                    begin
                        narrow_beta = rd_entry.value;
                    end
                end
                default:
                begin
                    narrow_alpha = in_reg.alpha;
                end
            endcase
            if (rd_entry.bound != BND_EXACT && narrow_alpha >= narrow_beta)
            begin
                cut = 1'b1;
            end
        end
    end

    // Store: classify the bound against the original window
    always_comb
    begin
        if (in_reg.score <= in_reg.alpha)
        begin
            store_bound = BND_UPPER;
        end
        else if (in_reg.score >= in_reg.beta)
        begin
            store_bound = BND_LOWER;
        end
        else
        begin
            store_bound = BND_EXACT;
        end
    end

    // Assemble the result; a store reports only whether it replaced the slot
    always_comb
    begin
        result = '0;
        if (op_reg == OP_PROBE)
        begin
            result.hit       = key_match;
            result.cut       = cut;
            result.cut_value = cut ? rd_entry.value : '0;
            result.new_alpha = narrow_alpha;
            result.new_beta  = narrow_beta;
            result.hint_move = key_match ? HMOVE_W'(rd_entry.move) : NO_MOVE;
        end
        else
        begin
            result.written = store_wins;
        end
    end

    // Sequencer: clearing pass, idle, resolve
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        in_next        = in_reg;
        op_next        = op_reg;
        ram_we         = 1'b0;
        ram_waddr      = in_reg.key[INDEX_BITS-1:0];
        ram_wentry     = '{
            key:   in_reg.key,
            value: in_reg.score,
            depth: $signed({1'b0, in_reg.depth}),
            bound: store_bound,
            move:  MOVE_BITS'(in_reg.move_code)
        };

        // Drop the result once the sink takes it
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                // Write an empty entry to every slot, one per cycle
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wentry   = EMPTY_ENTRY;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (&clr_cnt_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    in_next    = s_req;
                    op_next    = op_t'(s_axis_tuser);
                    state_next = ST_RESOLVE;
                end
            end
            ST_RESOLVE:
            begin
                // Hold the request until the output register is free, then
                // write back and load the result in the same cycle
                if (out_free)
                begin
                    ram_we         = (op_reg == OP_STORE) && store_wins;
                    out_data_next  = result;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg       <= in_next;
        op_reg       <= op_next;
        out_data_reg <= out_data_next;
    end

endmodule

### hw/rtl/ttps_ram.sv
`timescale 1ns / 1ps

module ttps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read; hold the last word while no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hw/rtl/ttps_chk.sv
`timescale 1ns / 1ps

module ttps_chk (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [ttps_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input logic                           s_axis_tuser,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [ttps_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    import ttps_pkg::*;

    out_t res;

    assign res = out_t'(m_axis_tdata);

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // One request in flight: no accept in the cycle after an accept
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while previous one unresolved");

    // A cut needs a hit
    a_cut_hit: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && res.cut |-> res.hit)
        else $error("cut without hit");

    // A store result carries no probe flags
    a_store_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && res.written |-> !res.hit && !res.cut && res.hint_move == NO_MOVE)
        else $error("store result carries probe fields");

    // No cut means a zero cut value
    a_cut_value: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !res.cut |-> res.cut_value == '0)
        else $error("cut value set without cut");

endmodule

bind transposition_table_probe_store ttps_chk u_ttps_chk (.*);
